### hw/rtl/afd_pkg.sv
// Package for the ASCII frame deframer: parser state, result record,
// character codes, status codes and small helper functions.
// No dependencies.
`timescale 1ns / 1ps

package afd_pkg;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_HEAD   = 7'b0000010,
    PH_NAME   = 7'b0000100,
    PH_FIELDS = 7'b0001000,
    PH_CK1    = 7'b0010000,
    PH_CK2    = 7'b0100000,
    PH_TAIL   = 7'b1000000
  } phase_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_LEN    = 3'd1;
  localparam status_t ST_CHECK  = 3'd2;
  localparam status_t ST_REJECT = 3'd3;
  localparam status_t ST_NAME   = 3'd4;
  localparam status_t ST_OVER   = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA      = 2'd0;
  localparam kind_t KIND_FIELD_END = 2'd1;
  localparam kind_t KIND_FRAME_END = 2'd2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FILTER_NAME = 1'd0;
  localparam cfg_idx_t CFG_FILTER_LEN  = 1'd1;

  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [5:0] NAME_CNT_MAX = 6'd63;
  localparam logic [6:0] FIELD_MAX    = 7'd127;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] decl_len;
    logic [7:0] run_xor;
    logic [7:0] rx_check;
    logic [5:0] name_cnt;
    logic       name_match;
    logic [6:0] cur_field;
    status_t    perr;
  } afd_state_t;

  localparam afd_state_t STATE_CLEAR = '{
    phase:      PH_IDLE,
    decl_len:   8'd0,
    run_xor:    8'd0,
    rx_check:   8'd0,
    name_cnt:   6'd0,
    name_match: 1'b1,
    cur_field:  7'd0,
    perr:       ST_OK
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] field;
    status_t    status;
  } afd_result_t;

  // {valid, value}; invalid digits read as zero
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [1:0] err_rank(input status_t code);
    logic [1:0] r;
    case (code)
      ST_LEN:   r = 2'd3;
      ST_CHECK: r = 2'd2;
      ST_NAME:  r = 2'd1;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic status_t raise_err(input status_t cur, input status_t code);
    return (err_rank(code) > err_rank(cur)) ? code : cur;
  endfunction

endpackage

### hw/rtl/afd_step.sv
// Per-byte parse step of the ASCII frame deframer: next parser state,
// frame position and at most one result. Purely combinational.
// Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_step import afd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int NAME_CHARS      = 8,
  parameter int MAX_NAME_ACCEPT = 32,
  parameter int POS_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic [7:0]              rx_byte,
  input  afd_state_t              st,
  input  logic [POS_W-1:0]        pos,
  input  logic [NAME_CHARS*8-1:0] filter_name,
  input  logic [3:0]              filter_len,
  output afd_state_t              st_nxt,
  output logic [POS_W-1:0]        pos_nxt,
  output logic                    res_vld,
  output afd_result_t             res
);

  localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

  logic [3:0] flen;
  logic       at_decl;
  logic       byte_hit;
  logic [4:0] hex_c;
  logic [5:0] name_cnt_inc;
  status_t    fin_status;

  assign flen    = (filter_len > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : filter_len;
  assign at_decl = (CMP_W'(pos) == CMP_W'(st.decl_len));
  assign hex_c   = hex_val(rx_byte);
  assign name_cnt_inc = (st.name_cnt < NAME_CNT_MAX) ? st.name_cnt + 6'd1 : st.name_cnt;

  always_comb begin
    byte_hit = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (st.name_cnt == 6'(i) && filter_name[i*8 +: 8] == rx_byte) begin
        byte_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (st.perr == ST_LEN) begin
      fin_status = ST_LEN;
    end else if (st.perr == ST_CHECK || st.run_xor != st.rx_check) begin
      fin_status = ST_CHECK;
    end else if (st.perr == ST_NAME) begin
      fin_status = ST_NAME;
    end else if (!st.name_match) begin
      fin_status = ST_REJECT;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_comb begin
    st_nxt  = st;
    pos_nxt = pos;
    res_vld = 1'b0;
    res     = '{kind: KIND_DATA, data: 8'd0, field: 7'd0, status: ST_OK};

    if (rx_byte == CH_TILDE) begin
      st_nxt       = STATE_CLEAR;
      st_nxt.phase = PH_HEAD;
      pos_nxt      = POS_W'(1);
    end else if (st.phase == PH_IDLE) begin
      st_nxt = st;
    end else if (pos >= POS_W'(MAX_FRAME_BYTES)) begin
      st_nxt     = STATE_CLEAR;
      pos_nxt    = '0;
      res_vld    = 1'b1;
      res.kind   = KIND_FRAME_END;
      res.status = ST_OVER;
    end else if (rx_byte == CH_NL) begin
      st_nxt   = STATE_CLEAR;
      pos_nxt  = '0;
      res_vld  = 1'b1;
      res.kind = KIND_FRAME_END;
      if (st.phase == PH_TAIL) begin
        res.status = fin_status;
      end else if (st.phase == PH_CK1 || st.phase == PH_CK2) begin
        res.status = (st.perr == ST_LEN) ? ST_LEN : ST_CHECK;
      end else begin
        res.status = ST_LEN;
      end
    end else begin
      pos_nxt = pos + POS_W'(1);
      unique case (st.phase)
        PH_HEAD: begin
          st_nxt.run_xor = st.run_xor ^ rx_byte;
          if (pos <= POS_W'(2)) begin
            if (!hex_c[4]) begin
              st_nxt.perr = raise_err(st.perr, ST_LEN);
            end
            st_nxt.decl_len = {st.decl_len[3:0], hex_c[3:0]};
          end else begin
            st_nxt.phase = PH_NAME;
          end
        end
        PH_NAME: begin
          st_nxt.run_xor = st.run_xor ^ rx_byte;
          if (at_decl && rx_byte != CH_RBRACE) begin
            st_nxt.perr = raise_err(st.perr, ST_LEN);
          end
          if (rx_byte == CH_LBRACE) begin
            st_nxt.phase = PH_FIELDS;
            if (flen != 4'd0) begin
              if (st.name_cnt != 6'(flen)) begin
                st_nxt.name_match = 1'b0;
              end
              st_nxt.cur_field = 7'd0;
            end else begin
              st_nxt.cur_field = 7'd1;
              res_vld   = 1'b1;
              res.kind  = KIND_FIELD_END;
            end
          end else begin
            if (flen != 4'd0 && (st.name_cnt >= 6'(flen) || !byte_hit)) begin
              st_nxt.name_match = 1'b0;
            end
            st_nxt.name_cnt = name_cnt_inc;
            if (name_cnt_inc > 6'(MAX_NAME_ACCEPT)) begin
              st_nxt.perr = raise_err(st_nxt.perr, ST_NAME);
            end else if (flen == 4'd0) begin
              res_vld  = 1'b1;
              res.kind = KIND_DATA;
              res.data = rx_byte;
            end
          end
        end
        PH_FIELDS: begin
          st_nxt.run_xor = st.run_xor ^ rx_byte;
          if (rx_byte == CH_RBRACE) begin
            if (!at_decl) begin
              st_nxt.perr = raise_err(st.perr, ST_LEN);
            end
            st_nxt.phase = PH_CK1;
            res_vld   = st.name_match;
            res.kind  = KIND_FIELD_END;
            res.field = st.cur_field;
          end else begin
            if (at_decl) begin
              st_nxt.perr = raise_err(st.perr, ST_LEN);
            end
            res_vld   = st.name_match;
            res.field = st.cur_field;
            if (rx_byte == CH_BAR) begin
              if (st.cur_field < FIELD_MAX) begin
                st_nxt.cur_field = st.cur_field + 7'd1;
              end
              res.kind = KIND_FIELD_END;
            end else begin
              res.kind = KIND_DATA;
              res.data = rx_byte;
            end
          end
        end
        PH_CK1, PH_CK2: begin
          if (!hex_c[4]) begin
            st_nxt.perr = raise_err(st.perr, ST_CHECK);
          end
          st_nxt.rx_check = {st.rx_check[3:0], hex_c[3:0]};
          st_nxt.phase    = (st.phase == PH_CK1) ? PH_CK2 : PH_TAIL;
        end
        PH_TAIL: begin
          st_nxt = st;
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

### hw/rtl/ascii_frame_deframer.sv
// Top level of the ASCII frame deframer: input register, parser state,
// result register and configuration registers. Depends on afd_pkg, afd_step.
//
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one received byte
//   per transaction. Frames look like '~' LL '|' name '{' f '|' f ... '}' CC
//   newline; a '~' restarts a frame at any point.
//   Result channel (out_valid / out_stall / out_*) carries name and field
//   bytes, end-of-field marks and one end-of-frame transaction with status.
//   Configuration port (cfg_we / cfg_index / cfg_wdata): index 0 is the
//   sender filter name, index 1 its length; write only while idle.
// Timing:
//   One byte per cycle sustained while in_stall stays low. A taken byte is held
//   in the input register and then parsed into the result register, which
//   drives the result channel. The input register and result register form a
//   skid pair: a byte is still taken while a result waits.
// Reset: parser goes idle with no frame open, filter cleared, both registers
//   empty. A stalled result holds; once the input register also holds a byte
//   that yields a result, in_stall rises until the stalled result is taken.
`timescale 1ns / 1ps

module ascii_frame_deframer import afd_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 256,
  parameter int NAME_CHARS      = 8,
  parameter int MAX_NAME_ACCEPT = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_result_kind,
  output logic [7:0]            out_data_byte,
  output logic [6:0]            out_field_index,
  output logic [2:0]            out_frame_status,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic                    in_vld_r;
  logic [7:0]              in_byte_r;
  afd_state_t              st_r;
  afd_state_t              st_nxt;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        pos_nxt;
  logic                    out_vld_r;
  afd_result_t             out_res_r;
  logic [NAME_CHARS*8-1:0] filter_name_r;
  logic [3:0]              filter_len_r;
  logic                    res_vld_c;
  afd_result_t             res_c;
  logic                    proc;

  afd_step #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .NAME_CHARS      (NAME_CHARS),
    .MAX_NAME_ACCEPT (MAX_NAME_ACCEPT),
    .POS_W           (POS_W)
  ) u_step (
    .rx_byte     (in_byte_r),
    .st          (st_r),
    .pos         (pos_r),
    .filter_name (filter_name_r),
    .filter_len  (filter_len_r),
    .st_nxt      (st_nxt),
    .pos_nxt     (pos_nxt),
    .res_vld     (res_vld_c),
    .res         (res_c)
  );

  assign proc     = in_vld_r && (!out_vld_r || !out_stall || !res_vld_c);
  assign in_stall = in_vld_r && !proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_name_r <= '0;
      filter_len_r  <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_NAME: filter_name_r <= cfg_wdata[NAME_CHARS*8-1:0];
        CFG_FILTER_LEN:  filter_len_r  <= cfg_wdata[3:0];
        default:         filter_len_r  <= filter_len_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_CLEAR;
      pos_r <= '0;
    end else if (proc) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && res_vld_c) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_vld_c) begin
      out_res_r <= res_c;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_data_byte    = out_res_r.data;
  assign out_field_index  = out_res_r.field;
  assign out_frame_status = out_res_r.status;

`ifndef SYNTH
  a_frame_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
    proc && res_vld_c && res_c.kind == KIND_FRAME_END |=> st_r.phase == PH_IDLE)
    else $error("parser not idle after end of frame");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_FRAME_BYTES))
    else $error("frame position beyond limit");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IDLE |-> pos_r == '0)
    else $error("frame position held while idle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked result");

  a_status_only_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.kind != KIND_FRAME_END |-> out_res_r.status == ST_OK)
    else $error("status on a non frame-end result");
`endif

endmodule
